/* rtl/zpconv_pkg.sv */
package zpconv_pkg;

  localparam int IMAGE_DIM  = 512;
  localparam int KERNEL_DIM = 5;
  localparam int KCENTER    = (KERNEL_DIM - 1) / 2;
  localparam int KTAPS      = KERNEL_DIM * KERNEL_DIM;

  localparam int CMD_W   = 2;
  localparam int COORD_W = 9;
  localparam int PIX_W   = 8;
  localparam int KIDX_W  = 5;
  localparam int COEF_W  = 16;
  localparam int FILT_W  = 29;

  // Signed window position: two extra bits cover the negative offsets and the carry.
  localparam int POS_W  = COORD_W + 2;
  localparam int IMG_AW = $clog2(IMAGE_DIM * IMAGE_DIM);
  localparam int KOFF_W = $clog2(KERNEL_DIM);
  localparam int PROD_W = COEF_W + PIX_W + 1;

  localparam logic [CMD_W-1:0] CMD_WR_COEF = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_PIX  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

  typedef struct packed {
    logic                img_we;
    logic [IMG_AW-1:0]   img_addr;
    logic [PIX_W-1:0]    pix;
    logic                coef_we;
    logic [KIDX_W-1:0]   coef_addr;
    logic [COEF_W-1:0]   coef;
  } wr_t;

  typedef struct packed {
    logic                valid;
    logic                hit;
    logic                last;
    logic [IMG_AW-1:0]   img_addr;
    logic [KIDX_W-1:0]   coef_addr;
  } tap_t;

  typedef struct packed {
    logic idle;
    logic load;
  } seq_ctl_t;

  function automatic logic on_image(logic [POS_W-1:0] pos);
    return !pos[POS_W-1] && (pos < POS_W'(IMAGE_DIM));
  endfunction

  function automatic logic [IMG_AW-1:0] img_addr(logic [POS_W-1:0] r, logic [POS_W-1:0] c);
    return IMG_AW'(r) * IMG_AW'(IMAGE_DIM) + IMG_AW'(c);
  endfunction

endpackage

/* rtl/zpconv_if.sv */
interface zpconv_in_if;
  import zpconv_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [COORD_W-1:0]  pixel_row;
  logic [COORD_W-1:0]  pixel_col;
  logic [PIX_W-1:0]    pixel_value;
  logic [KIDX_W-1:0]   coef_index;
  logic signed [COEF_W-1:0] coef_value;

  modport source (
    output valid, cmd, pixel_row, pixel_col, pixel_value, coef_index, coef_value,
    input  ready
  );
  modport sink (
    input  valid, cmd, pixel_row, pixel_col, pixel_value, coef_index, coef_value,
    output ready
  );
endinterface

interface zpconv_out_if;
  import zpconv_pkg::*;

  logic                valid;
  logic                ready;
  logic [COORD_W-1:0]  out_row;
  logic [COORD_W-1:0]  out_col;
  logic signed [FILT_W-1:0] filtered;

  modport source (
    output valid, out_row, out_col, filtered,
    input  ready
  );
  modport sink (
    input  valid, out_row, out_col, filtered,
    output ready
  );
endinterface

/* rtl/zero_padded_2d_convolution_unit.sv */
// Zero-padded 5x5 convolution over a 512x512 grayscale image store. Each input
// transfer of cmd 0 writes one kernel coefficient, cmd 1 one pixel, and cmd 2 asks
// for the filtered value at a row and column; only cmd 2 yields a result.
// A compute request walks the 25 window taps through a single multiply-accumulate
// fed by the one read port of each store. After its transfer, in_ready stays low
// while the 25 taps are read, while the read, multiply and accumulate stages drain,
// and while the result is loaded. If the previous result is still waiting, the
// load step waits until it is taken. Taps outside the image count as zero, and the
// kernel is applied as a correlation, unflipped. The result waits in an output
// register, so writes keep flowing while it is not yet taken. Reading a pixel or
// coefficient that was never written gives an unspecified result.
module zero_padded_2d_convolution_unit (
  input  logic          clk,
  input  logic          rst_n,
  zpconv_in_if.sink     in_if,
  zpconv_out_if.source  out_if
);
  import zpconv_pkg::*;

  wr_t                 wr;
  tap_t                tap;
  seq_ctl_t            ctl;
  logic                accept;
  logic                start;
  logic                mac_done;
  logic                out_busy;
  logic signed [FILT_W-1:0] acc;
  logic [COORD_W-1:0]  seq_row, seq_col;

  logic                out_valid_r;
  logic [COORD_W-1:0]  out_row_r, out_col_r;
  logic signed [FILT_W-1:0] out_filt_r;

  assign accept = in_if.valid && in_if.ready;
  assign start  = accept && (in_if.cmd == CMD_COMPUTE);

  assign wr.img_we    = accept && (in_if.cmd == CMD_WR_PIX) &&
                        on_image(POS_W'(in_if.pixel_row)) &&
                        on_image(POS_W'(in_if.pixel_col));
  assign wr.img_addr  = img_addr(POS_W'(in_if.pixel_row), POS_W'(in_if.pixel_col));
  assign wr.pix       = in_if.pixel_value;
  assign wr.coef_we   = accept && (in_if.cmd == CMD_WR_COEF) &&
                        (in_if.coef_index < KIDX_W'(KTAPS));
  assign wr.coef_addr = in_if.coef_index;
  assign wr.coef      = in_if.coef_value;

  assign out_busy = out_valid_r && !out_if.ready;

  zpconv_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .row_in   (in_if.pixel_row),
    .col_in   (in_if.pixel_col),
    .mac_done (mac_done),
    .out_busy (out_busy),
    .ctl      (ctl),
    .tap      (tap),
    .row      (seq_row),
    .col      (seq_col)
  );

  zpconv_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (start),
    .wr    (wr),
    .tap   (tap),
    .done  (mac_done),
    .acc   (acc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      out_row_r  <= seq_row;
      out_col_r  <= seq_col;
      out_filt_r <= acc;
    end
  end

  assign in_if.ready     = ctl.idle;
  assign out_if.valid    = out_valid_r;
  assign out_if.out_row  = out_row_r;
  assign out_if.out_col  = out_col_r;
  assign out_if.filtered = out_filt_r;

endmodule

/* rtl/zpconv_seq.sv */
module zpconv_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [zpconv_pkg::COORD_W-1:0] row_in,
  input  logic [zpconv_pkg::COORD_W-1:0] col_in,
  input  logic                          mac_done,
  input  logic                          out_busy,
  output zpconv_pkg::seq_ctl_t          ctl,
  output zpconv_pkg::tap_t              tap,
  output logic [zpconv_pkg::COORD_W-1:0] row,
  output logic [zpconv_pkg::COORD_W-1:0] col
);
  import zpconv_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [COORD_W-1:0]  row_r, row_nxt;
  logic [COORD_W-1:0]  col_r, col_nxt;
  logic [KOFF_W-1:0]   kr_r, kr_nxt;
  logic [KOFF_W-1:0]   kc_r, kc_nxt;
  logic [KIDX_W-1:0]   kidx_r, kidx_nxt;
  logic [POS_W-1:0]    pos_r;
  logic [POS_W-1:0]    pos_c;
  logic                last_tap;

  assign last_tap = (kidx_r == KIDX_W'(KTAPS - 1));

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    kr_nxt    = kr_r;
    kc_nxt    = kc_r;
    kidx_nxt  = kidx_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_RUN;
          row_nxt   = row_in;
          col_nxt   = col_in;
          kr_nxt    = '0;
          kc_nxt    = '0;
          kidx_nxt  = '0;
        end
      end
      S_RUN: begin
        if (last_tap) begin
          state_nxt = S_DRAIN;
        end else begin
          kidx_nxt = kidx_r + 1'b1;
          if (kc_r == KOFF_W'(KERNEL_DIM - 1)) begin
            kc_nxt = '0;
            kr_nxt = kr_r + 1'b1;
          end else begin
            kc_nxt = kc_r + 1'b1;
          end
        end
      end
      S_DRAIN: begin
        if (mac_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r  <= row_nxt;
    col_r  <= col_nxt;
    kr_r   <= kr_nxt;
    kc_r   <= kc_nxt;
    kidx_r <= kidx_nxt;
  end

  // Window position of the current tap; negative values wrap into the top bit.
  assign pos_r = POS_W'(row_r) + POS_W'(kr_r) - POS_W'(KCENTER);
  assign pos_c = POS_W'(col_r) + POS_W'(kc_r) - POS_W'(KCENTER);

  assign tap.valid     = (state_r == S_RUN);
  assign tap.hit       = (state_r == S_RUN) && on_image(pos_r) && on_image(pos_c);
  assign tap.last      = (state_r == S_RUN) && last_tap;
  assign tap.img_addr  = img_addr(pos_r, pos_c);
  assign tap.coef_addr = kidx_r;

  assign ctl.idle = (state_r == S_IDLE);
  assign ctl.load = (state_r == S_DONE) && !out_busy;

  assign row = row_r;
  assign col = col_r;

endmodule

/* rtl/zpconv_mac.sv */
module zpconv_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                clr,
  input  zpconv_pkg::wr_t                     wr,
  input  zpconv_pkg::tap_t                    tap,
  output logic                                done,
  output logic signed [zpconv_pkg::FILT_W-1:0] acc
);
  import zpconv_pkg::*;

  logic [PIX_W-1:0]          img_mem [IMAGE_DIM*IMAGE_DIM];
  logic signed [COEF_W-1:0]  coef_mem [KTAPS];

  logic [PIX_W-1:0]          img_q_r;
  logic signed [COEF_W-1:0]  coef_q_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [FILT_W-1:0]  acc_r;
  logic                      hit1_r, last1_r;
  logic                      hit2_r, last2_r;
  logic                      done_r;

  // Each store has one read port; writes only happen while no tap is being read.
  always_ff @(posedge clk) begin
    if (wr.img_we) begin
      img_mem[wr.img_addr] <= wr.pix;
    end
    img_q_r <= img_mem[tap.img_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.coef_we) begin
      coef_mem[wr.coef_addr] <= wr.coef;
    end
    coef_q_r <= coef_mem[tap.coef_addr];
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(coef_q_r * $signed({1'b0, img_q_r}));
    if (clr) begin
      acc_r <= '0;
    end else if (hit2_r) begin
      acc_r <= acc_r + FILT_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit1_r  <= 1'b0;
      last1_r <= 1'b0;
      hit2_r  <= 1'b0;
      last2_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      hit1_r  <= tap.valid && tap.hit;
      last1_r <= tap.last;
      hit2_r  <= hit1_r;
      last2_r <= last1_r;
      done_r  <= last2_r;
    end
  end

  assign done = done_r;
  assign acc  = acc_r;

endmodule

/* rtl/zpconv_checker.sv */
module zpconv_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [zpconv_pkg::CMD_W-1:0]        in_cmd,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [zpconv_pkg::COORD_W-1:0]      out_row,
  input  logic [zpconv_pkg::COORD_W-1:0]      out_col,
  input  logic signed [zpconv_pkg::FILT_W-1:0] filtered
);
  import zpconv_pkg::*;

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_row) && $stable(out_col) && $stable(filtered))
    else $error("stalled result changed");

  // An accepted compute request closes the input side behind it.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == CMD_COMPUTE) |=> !in_ready)
    else $error("input accepted during a compute request");

  // A new result only appears at the end of a busy period.
  a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a compute request in progress");

  // A write never produces a result right after its transfer.
  a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd != CMD_COMPUTE) |=> !$rose(out_valid))
    else $error("result appeared after a write");

endmodule

bind zero_padded_2d_convolution_unit zpconv_checker u_zpconv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .in_cmd    (in_if.cmd),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_row   (out_if.out_row),
  .out_col   (out_if.out_col),
  .filtered  (out_if.filtered)
);

/* tb/zero_padded_2d_convolution_unit_test.sv */
module zero_padded_2d_convolution_unit_test;
  import zpconv_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int STIM_ITEMS     = 1450;
  localparam int PHASE_ITEMS    = 150;
  localparam int LONG_HOLD      = 400;
  localparam int HOLD_SPACING   = 250;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 64;
  localparam int N_HOT          = 8;
  localparam int KIDX_MAX       = (1 << KIDX_W) - 1;

  typedef enum int {
    KS_MIXED, KS_RANDOM, KS_SMALL, KS_SPARSE, KS_MAX, KS_MIN
  } kernel_style_e;

  typedef struct {
    logic [CMD_W-1:0]         cmd;
    logic [COORD_W-1:0]       row;
    logic [COORD_W-1:0]       col;
    logic [PIX_W-1:0]         value;
    logic [KIDX_W-1:0]        kidx;
    logic signed [COEF_W-1:0] coef;
  } conv_cmd_t;

  typedef struct {
    logic [COORD_W-1:0]       row;
    logic [COORD_W-1:0]       col;
    logic signed [FILT_W-1:0] filtered;
  } conv_result_t;

  bit clk;
  bit rst_n;

  zpconv_in_if  in_ch ();
  zpconv_out_if out_ch ();

  zero_padded_2d_convolution_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  conv_cmd_t                pending_cmds[$];
  conv_result_t             expected_results[$];
  bit                       pix_planned[int];
  logic [PIX_W-1:0]         image_copy[int];
  logic signed [COEF_W-1:0] kernel_copy[KTAPS];

  int hot_row[N_HOT];
  int hot_col[N_HOT];
  int planned_useful;

  int mismatches;
  int results_checked;
  int pix_writes;
  int coef_writes;
  int ignored_cmds;
  int in_stall_cycles;
  int quiet_cycles;
  bit in_fire;

  int burst_left;
  int gap_left;
  int hold_left;
  int next_hold_at = 30;
  int style_left;
  int stall_style;
  int stall_tick;

  initial forever #6 clk = ~clk;

  function automatic int clamp_coord(int v);
    return (v < 0) ? 0 : (v > IMAGE_DIM - 1) ? IMAGE_DIM - 1 : v;
  endfunction

  // Fields that the command does not use still carry random values.
  function automatic conv_cmd_t noise_cmd(logic [CMD_W-1:0] cmd);
    conv_cmd_t w;
    w.cmd   = cmd;
    w.row   = COORD_W'($urandom_range(0, IMAGE_DIM - 1));
    w.col   = COORD_W'($urandom_range(0, IMAGE_DIM - 1));
    w.value = PIX_W'($urandom_range(0, 255));
    w.kidx  = KIDX_W'($urandom_range(0, KIDX_MAX));
    w.coef  = COEF_W'($urandom_range(0, 65535));
    return w;
  endfunction

  function automatic void queue_coef(int idx, int val);
    conv_cmd_t w;
    w      = noise_cmd(CMD_WR_COEF);
    w.kidx = KIDX_W'(idx);
    w.coef = COEF_W'(val);
    pending_cmds.push_back(w);
    if (idx < KTAPS) planned_useful++;
  endfunction

  function automatic void queue_pixel(int r, int c, int v);
    conv_cmd_t w;
    w       = noise_cmd(CMD_WR_PIX);
    w.row   = COORD_W'(r);
    w.col   = COORD_W'(c);
    w.value = PIX_W'(v);
    pending_cmds.push_back(w);
    pix_planned[r * IMAGE_DIM + c] = 1'b1;
    planned_useful++;
  endfunction

  // A request is only sent once every in-image pixel of its window has been
  // written, so the block never reads an uninitialized entry. A negative fill
  // means random pixel values.
  function automatic void queue_compute(int r, int c, int fill);
    conv_cmd_t w;
    for (int dr = -KCENTER; dr < KERNEL_DIM - KCENTER; dr++) begin
      for (int dc = -KCENTER; dc < KERNEL_DIM - KCENTER; dc++) begin
        if (r + dr >= 0 && r + dr < IMAGE_DIM && c + dc >= 0 && c + dc < IMAGE_DIM &&
            !pix_planned.exists((r + dr) * IMAGE_DIM + c + dc))
          queue_pixel(r + dr, c + dc, (fill < 0) ? int'($urandom_range(0, 255)) : fill);
      end
    end
    w     = noise_cmd(CMD_COMPUTE);
    w.row = COORD_W'(r);
    w.col = COORD_W'(c);
    pending_cmds.push_back(w);
    planned_useful++;
  endfunction

  function automatic void queue_kernel(kernel_style_e style);
    int first;
    int v;
    first = $urandom_range(0, KTAPS - 1);
    for (int i = 0; i < KTAPS; i++) begin
      case (style)
        KS_MIXED:  v = (i % 4 == 0) ? -32768 : (i % 4 == 1) ? 32767 : (i % 4 == 2) ? 0 : i - 12;
        KS_SMALL:  v = int'($urandom_range(0, 16)) - 8;
        KS_SPARSE: v = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535)) - 32768 : 0;
        KS_MAX:    v = 32767;
        KS_MIN:    v = -32768;
        default:   v = int'($urandom_range(0, 65535)) - 32768;
      endcase
      queue_coef((first + i) % KTAPS, v);
    end
  endfunction

  // Correlation over the window; taps off the image contribute nothing.
  function automatic logic signed [FILT_W-1:0] window_response(int row, int col);
    longint acc;
    int r;
    int c;
    int key;
    acc = 0;
    for (int kr = 0; kr < KERNEL_DIM; kr++) begin
      for (int kc = 0; kc < KERNEL_DIM; kc++) begin
        r = row + kr - KCENTER;
        c = col + kc - KCENTER;
        if (r >= 0 && r < IMAGE_DIM && c >= 0 && c < IMAGE_DIM) begin
          key = r * IMAGE_DIM + c;
          if (image_copy.exists(key))
            acc += longint'(kernel_copy[kr * KERNEL_DIM + kc]) * longint'(image_copy[key]);
        end
      end
    end
    return acc[FILT_W-1:0];
  endfunction

  function automatic void absorb_transfer(conv_cmd_t w);
    conv_result_t res;
    case (w.cmd)
      CMD_WR_COEF: begin
        if (w.kidx < KTAPS) begin
          kernel_copy[w.kidx] = w.coef;
          coef_writes++;
        end else begin
          ignored_cmds++;
        end
      end
      CMD_WR_PIX: begin
        image_copy[int'(w.row) * IMAGE_DIM + int'(w.col)] = w.value;
        pix_writes++;
      end
      CMD_COMPUTE: begin
        res.row      = w.row;
        res.col      = w.col;
        res.filtered = window_response(int'(w.row), int'(w.col));
        expected_results.push_back(res);
      end
      default: ignored_cmds++;
    endcase
  endfunction

  always @(negedge clk) begin : drive_cmds
    conv_cmd_t head;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (gap_left > 0 || pending_cmds.size() == 0) begin
        in_ch.valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        head = pending_cmds[0];
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= head.cmd;
        in_ch.pixel_row   <= head.row;
        in_ch.pixel_col   <= head.col;
        in_ch.pixel_value <= head.value;
        in_ch.coef_index  <= head.kidx;
        in_ch.coef_value  <= head.coef;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // Now and then the result side stops for a long stretch so that a finished
  // result sits in the output register and the next request backs up the input.
  always @(negedge clk) begin : drive_ready
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (results_checked >= next_hold_at) begin
      hold_left    = LONG_HOLD;
      next_hold_at = next_hold_at + HOLD_SPACING;
      out_ch.ready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        stall_style = $urandom_range(0, 3);
        style_left  = $urandom_range(20, 200);
      end
      style_left--;
      stall_tick++;
      case (stall_style)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 1) != 0);
        2:       out_ch.ready <= ((stall_tick % 5) < 3);
        default: out_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin : monitor
    conv_result_t want;
    if (!rst_n) begin
      in_fire      <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      in_fire <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && !in_ch.ready) in_stall_cycles++;
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;

      // Results are checked before this edge's input transfer is absorbed.
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: row %0d col %0d filtered %0d", $time,
                   out_ch.out_row, out_ch.out_col, out_ch.filtered);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (out_ch.out_row !== want.row || out_ch.out_col !== want.col ||
              out_ch.filtered !== want.filtered) begin
            $display("%0t: mismatch: expected row %0d col %0d filtered %0d, got row %0d col %0d filtered %0d",
                     $time, want.row, want.col, want.filtered,
                     out_ch.out_row, out_ch.out_col, out_ch.filtered);
            mismatches++;
          end
        end
      end

      if (in_ch.valid && in_ch.ready) absorb_transfer(pending_cmds.pop_front());
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    kernel_style_e style;
    int next_phase_at;
    int pick;
    int h;
    int r;
    int c;

    in_ch.valid       = 1'b0;
    in_ch.cmd         = CMD_UNUSED;
    in_ch.pixel_row   = '0;
    in_ch.pixel_col   = '0;
    in_ch.pixel_value = '0;
    in_ch.coef_index  = '0;
    in_ch.coef_value  = '0;
    out_ch.ready      = 1'b0;

    // Corners, a spot on the top row, one on the right column, one random spot and
    // one interior spot kept clear of the border for the all-saturated windows.
    hot_row[0] = 0;                                  hot_col[0] = 0;
    hot_row[1] = 0;                                  hot_col[1] = IMAGE_DIM - 1;
    hot_row[2] = IMAGE_DIM - 1;                      hot_col[2] = 0;
    hot_row[3] = IMAGE_DIM - 1;                      hot_col[3] = IMAGE_DIM - 1;
    hot_row[4] = 0;                                  hot_col[4] = $urandom_range(0, IMAGE_DIM - 1);
    hot_row[5] = $urandom_range(0, IMAGE_DIM - 1);   hot_col[5] = IMAGE_DIM - 1;
    hot_row[6] = $urandom_range(0, IMAGE_DIM - 1);   hot_col[6] = $urandom_range(0, IMAGE_DIM - 1);
    hot_row[7] = $urandom_range(KCENTER, IMAGE_DIM - 1 - KCENTER);
    hot_col[7] = $urandom_range(KCENTER, IMAGE_DIM - 1 - KCENTER);

    // Directed opening: extreme coefficients, ignored index and command codes,
    // and requests at two clipped corners.
    queue_kernel(KS_MIXED);
    queue_coef(KTAPS, $urandom_range(0, 65535));
    queue_coef(KIDX_MAX, $urandom_range(0, 65535));
    pending_cmds.push_back(noise_cmd(CMD_UNUSED));
    queue_compute(0, 0, 255);
    queue_compute(IMAGE_DIM - 1, IMAGE_DIM - 1, 0);

    planned_useful = 0;
    next_phase_at  = 0;
    while (planned_useful < STIM_ITEMS) begin
      if (planned_useful >= next_phase_at) begin
        style = kernel_style_e'($urandom_range(KS_RANDOM, KS_MIN));
        queue_kernel(style);
        // An all-extreme kernel over an all-255 window reaches the extreme sums.
        if (style == KS_MAX || style == KS_MIN) begin
          for (int dr = -KCENTER; dr < KERNEL_DIM - KCENTER; dr++)
            for (int dc = -KCENTER; dc < KERNEL_DIM - KCENTER; dc++)
              queue_pixel(hot_row[7] + dr, hot_col[7] + dc, 255);
          queue_compute(hot_row[7], hot_col[7], -1);
        end
        next_phase_at = planned_useful + PHASE_ITEMS;
      end
      pick = $urandom_range(0, 99);
      h    = $urandom_range(0, N_HOT - 1);
      r    = clamp_coord(hot_row[h] + int'($urandom_range(0, 4)) - 2);
      c    = clamp_coord(hot_col[h] + int'($urandom_range(0, 4)) - 2);
      if (pick < 45)
        queue_compute(r, c, -1);
      else if (pick < 47)
        queue_compute($urandom_range(0, IMAGE_DIM - 1), $urandom_range(0, IMAGE_DIM - 1), -1);
      else if (pick < 72)
        queue_pixel(r, c, $urandom_range(0, 255));
      else if (pick < 82)
        queue_pixel($urandom_range(0, IMAGE_DIM - 1), $urandom_range(0, IMAGE_DIM - 1),
                    $urandom_range(0, 255));
      else if (pick < 90)
        queue_coef($urandom_range(0, KTAPS - 1), $urandom_range(0, 65535));
      else if (pick < 95)
        queue_coef($urandom_range(KTAPS, KIDX_MAX), $urandom_range(0, 65535));
      else
        pending_cmds.push_back(noise_cmd(CMD_UNUSED));
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d filtered pixels after %0d pixel writes and %0d coefficient writes (%0d ignored commands).",
             results_checked, pix_writes, coef_writes, ignored_cmds);
    $display("The input was held back for %0d cycles, including long result-side stalls.",
             in_stall_cycles);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

/* sim.f */
rtl/zpconv_pkg.sv
rtl/zpconv_if.sv
rtl/zpconv_seq.sv
rtl/zpconv_mac.sv
rtl/zero_padded_2d_convolution_unit.sv
rtl/zpconv_checker.sv
tb/zero_padded_2d_convolution_unit_test.sv
